// File: rtl/pol_pkg.sv
// ============================================================================
// pol_pkg - shared definitions for the positional ordered list
// Sizes, operation and status codes, and the structs that pass between the
// sequencer, the entry store and the top level.
// ============================================================================
`default_nettype none

package pol_pkg;

    // List capacity and the widths that follow from it.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths of the transactions.
    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int ST_W   = 2;
    localparam int FPOS_W = 7;
    localparam int ECNT_W = 7;

    // Width used when positions are compared against the entry count.
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((FPOS_W + ECNT_W + 7) / 8) * 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_LAST = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH   = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_DONE = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;
    localparam logic [ST_W-1:0] ST_MISS = 2'd3;

    // Per-cycle commands from the sequencer to the entry store.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_key;   // 1: write the key, 0: write the read data
    } store_ctrl_t;

    // Finished result of one operation.
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [FPOS_W-1:0] fpos;
        logic [ECNT_W-1:0] ecnt;
    } resp_t;

endpackage

`default_nettype wire

// File: rtl/positional_ordered_list_top.sv
// ============================================================================
// positional_ordered_list_top - ordered list of signed values by position
// Insert, append, delete, delete-last and search on a packed list of up to
// DEPTH entries held in one single-port-read memory.
// ============================================================================
// Usage:
//   Each transaction on the slave channel carries one operation: the op code
//   in s_tuser and the value and 1-based position in s_tdata. Every
//   operation produces exactly one result transaction on the master channel:
//   the status in m_tuser, and the found position and new entry count in
//   m_tdata.
//   The block works on one operation at a time and drops s_tready from the
//   acceptance cycle until the result is loaded into the output register.
//   Checks, appends, deletes of the last entry, and inserts or deletes that
//   move no entries finish in the check step and go straight to the result.
//   Positional inserts and deletes move the entries behind the position one
//   per cycle through the memory's read and write ports, then write the last
//   moved word; an insert then writes the new value into the opened gap. A
//   search reads one entry per cycle from the head and stops at the first
//   match or after the last entry.
//   The output register lets a new operation be accepted while the previous
//   result waits; a stalled m_tready only holds back the following result.
//   Reset empties the list at once (the entry count is cleared; entry
//   contents are never read before they are written), so no clearing pass
//   is needed and s_tready is already high when reset is released.
// ============================================================================
`default_nettype none

module positional_ordered_list_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: value [31:0], position [39:32]
    input  wire logic [pol_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: op [2:0]
    input  wire logic [pol_pkg::OP_W-1:0]          s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: found_position [6:0], entry_count [13:7], zero padding above
    output logic [pol_pkg::OUT_DATA_W-1:0]         m_tdata,
    // m_tuser: status [1:0]
    output logic [pol_pkg::ST_W-1:0]               m_tuser
);

    pol_pkg::store_ctrl_t                 ctrl;
    logic signed [pol_pkg::VAL_W-1:0]     key;
    logic                                 match;
    logic                                 resp_valid;
    pol_pkg::resp_t                       resp;
    logic                                 resp_take;

    logic                                 out_valid_reg;
    pol_pkg::resp_t                       out_reg;

    // The result register is free when empty or being emptied this cycle.
    assign resp_take = !out_valid_reg || m_tready;

    pol_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_value   (s_tdata[pol_pkg::VAL_W-1:0]),
        .in_pos     (s_tdata[pol_pkg::VAL_W +: pol_pkg::POS_W]),
        .match      (match),
        .ctrl       (ctrl),
        .key        (key),
        .resp_valid (resp_valid),
        .resp       (resp),
        .resp_take  (resp_take)
    );

    pol_store u_store (
        .clk   (clk),
        .ctrl  (ctrl),
        .key   (key),
        .match (match)
    );

    // Output register: holds a finished result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (resp_valid && resp_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp_valid && resp_take)
        begin
            out_reg <= resp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = pol_pkg::OUT_DATA_W'({out_reg.ecnt, out_reg.fpos});

endmodule

`default_nettype wire

// File: rtl/pol_store.sv
// ============================================================================
// pol_store - entry memory with its move and compare path
// One write and one registered read per cycle; the write data is either the
// key or the last word read, and the read word is compared
// against the key.
// ============================================================================
`default_nettype none

module pol_store (
    input  wire logic                             clk,
    input  wire pol_pkg::store_ctrl_t             ctrl,
    input  wire logic signed [pol_pkg::VAL_W-1:0] key,
    output logic                                  match
);

    logic [pol_pkg::VAL_W-1:0] mem [pol_pkg::DEPTH];
    logic [pol_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_key ? key : rd_data_reg;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign match = (rd_data_reg == key);

endmodule

`default_nettype wire

// File: rtl/pol_seq.sv
// ============================================================================
// pol_seq - operation sequencer for the positional ordered list
// Checks each operation against the entry count, then steps the store one
// entry per cycle to open a gap, close a gap or scan for a value.
// ============================================================================
`default_nettype none

module pol_seq (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [pol_pkg::OP_W-1:0]          in_op,
    input  wire logic signed [pol_pkg::VAL_W-1:0]  in_value,
    input  wire logic [pol_pkg::POS_W-1:0]         in_pos,
    input  wire logic                              match,
    output pol_pkg::store_ctrl_t                   ctrl,
    output logic signed [pol_pkg::VAL_W-1:0]       key,
    output logic                                   resp_valid,
    output pol_pkg::resp_t                         resp,
    input  wire logic                              resp_take
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_PUT    = 3'd4;
    localparam logic [2:0] S_SEARCH = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    localparam int AW = pol_pkg::ADDR_W;
    localparam int CW = pol_pkg::CNT_W;
    localparam int XW = pol_pkg::CMP_W;

    logic [2:0]                      state_reg, state_next;
    logic [pol_pkg::OP_W-1:0]        op_reg, op_next;
    logic [pol_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic signed [pol_pkg::VAL_W-1:0] key_reg, key_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [AW-1:0]                   idx_reg, idx_next;
    logic [AW-1:0]                   last_reg, last_next;
    logic                            pend_reg, pend_next;
    logic [AW-1:0]                   pend_addr_reg, pend_addr_next;
    logic [pol_pkg::ST_W-1:0]        status_reg, status_next;
    logic [CW-1:0]                   fpos_reg, fpos_next;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic          full;
    logic          grow;
    logic [AW-1:0] dst_addr;

    assign pos_x = XW'(pos_reg);
    assign cnt_x = XW'(count_reg);
    assign full  = (cnt_x >= XW'(pol_pkg::DEPTH));

    // An insert moves entries toward the end, a delete toward the front.
    assign grow     = (op_reg == pol_pkg::OP_INSERT);
    assign dst_addr = grow ? (pend_addr_reg + AW'(1)) : (pend_addr_reg - AW'(1));

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        status_next    = status_reg;
        fpos_next      = fpos_reg;
        ctrl           = '0;
        in_ready       = 1'b0;
        resp_valid     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = in_op;
                    pos_next   = in_pos;
                    key_next   = in_value;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                pend_next   = 1'b0;
                fpos_next   = '0;
                status_next = pol_pkg::ST_DONE;
                state_next  = S_RESP;
                unique case (op_reg)
                    pol_pkg::OP_INSERT:
                    begin
                        if (pos_reg == '0)
                        begin
                            status_next = pol_pkg::ST_BAD;
                        end
                        else if (full)
                        begin
                            status_next = pol_pkg::ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            // Any position lands at the head of an empty list.
                            ctrl.wr_en   = 1'b1;
                            ctrl.wr_addr = '0;
                            ctrl.wr_key  = 1'b1;
                            count_next   = count_reg + CW'(1);
                        end
                        else if (pos_x > cnt_x + XW'(1))
                        begin
                            status_next = pol_pkg::ST_BAD;
                        end
                        else if (pos_x == cnt_x + XW'(1))
                        begin
                            ctrl.wr_en   = 1'b1;
                            ctrl.wr_addr = AW'(count_reg);
                            ctrl.wr_key  = 1'b1;
                            count_next   = count_reg + CW'(1);
                        end
                        else
                        begin
                            idx_next   = AW'(count_reg - CW'(1));
                            last_next  = AW'(pos_reg - pol_pkg::POS_W'(1));
                            state_next = S_SHIFT;
                        end
                    end

                    pol_pkg::OP_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = pol_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.wr_en   = 1'b1;
                            ctrl.wr_addr = AW'(count_reg);
                            ctrl.wr_key  = 1'b1;
                            count_next   = count_reg + CW'(1);
                        end
                    end

                    pol_pkg::OP_DEL_POS:
                    begin
                        if (pos_reg == '0 || count_reg == '0 || pos_x > cnt_x)
                        begin
                            status_next = pol_pkg::ST_BAD;
                        end
                        else if (pos_x < cnt_x)
                        begin
                            idx_next   = AW'(pos_reg);
                            last_next  = AW'(count_reg - CW'(1));
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end

                    pol_pkg::OP_DEL_LAST:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = pol_pkg::ST_BAD;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end

                    pol_pkg::OP_SEARCH:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = pol_pkg::ST_MISS;
                        end
                        else
                        begin
                            idx_next   = '0;
                            last_next  = AW'(count_reg - CW'(1));
                            state_next = S_SEARCH;
                        end
                    end

                    default:
                    begin
                        status_next = pol_pkg::ST_BAD;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // Write back the word read last cycle while reading the next.
                if (pend_reg)
                begin
                    ctrl.wr_en   = 1'b1;
                    ctrl.wr_addr = dst_addr;
                end
                ctrl.rd_en     = 1'b1;
                ctrl.rd_addr   = idx_reg;
                pend_next      = 1'b1;
                pend_addr_next = idx_reg;
                if (idx_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = grow ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
                end
            end

            S_DRAIN:
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_addr = dst_addr;
                pend_next    = 1'b0;
                if (grow)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_PUT:
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_addr = last_reg;
                ctrl.wr_key  = 1'b1;
                count_next   = count_reg + CW'(1);
                state_next   = S_RESP;
            end

            S_SEARCH:
            begin
                if (pend_reg && match)
                begin
                    status_next = pol_pkg::ST_DONE;
                    fpos_next   = CW'(pend_addr_reg) + CW'(1);
                    pend_next   = 1'b0;
                    state_next  = S_RESP;
                end
                else if (pend_reg && pend_addr_reg == last_reg)
                begin
                    status_next = pol_pkg::ST_MISS;
                    pend_next   = 1'b0;
                    state_next  = S_RESP;
                end
                else
                begin
                    ctrl.rd_en     = 1'b1;
                    ctrl.rd_addr   = idx_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    idx_next       = idx_reg + AW'(1);
                end
            end

            S_RESP:
            begin
                resp_valid = 1'b1;
                if (resp_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        fpos_reg      <= fpos_next;
    end

    assign key         = key_reg;
    assign resp.status = status_reg;
    assign resp.fpos   = pol_pkg::FPOS_W'(fpos_reg);
    assign resp.ecnt   = pol_pkg::ECNT_W'(count_reg);

    // A shift step never reads the entry it overwrites in the same cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wr_en && ctrl.rd_en) |-> (ctrl.wr_addr != ctrl.rd_addr))
        else $error("store read and write hit the same entry");

    // The entry count only moves when an operation finishes.
    a_count_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == S_RESP))
        else $error("entry count changed outside operation completion");

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) |-> (CW'(pol_pkg::DEPTH) >= count_reg))
        else $error("entry count above capacity");

    // A successful search reports a position inside the list.
    a_found_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && op_reg == pol_pkg::OP_SEARCH
            && status_reg == pol_pkg::ST_DONE)
        |-> (fpos_reg != '0 && fpos_reg <= count_reg))
        else $error("search hit outside the list");

endmodule

`default_nettype wire

// File: tb/positional_ordered_list_checker.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_checker - result checker for the ordered list
// Watches both stream channels of the list block. It keeps its own shadow copy
// of the list and predicts the result of every accepted operation. It then
// compares each accepted result against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_ordered_list_checker
    import pol_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [OP_W-1:0]       s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic [ST_W-1:0]       m_tuser,
    output int                         fail_count,
    output int                         pending,
    output int                         list_len
);

    // Shadow copy of the list, packed at positions 1..shadow_count.
    logic [VAL_W-1:0] shadow_entries [DEPTH];
    int               shadow_count  = 0;
    int               mismatches    = 0;
    int               waiting_cnt   = 0;
    int               results_seen  = 0;
    resp_t            awaited_results [$];

    assign fail_count = mismatches;
    assign pending    = waiting_cnt;
    assign list_len   = shadow_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on result %0d, %s: got %0h, expected %0h",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // Applies one operation to the shadow list and returns its result.
    task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                                 input logic [POS_W-1:0] pos, output resp_t res);
        int  i;
        int  slot;
        bit  hit;
        res        = '0;
        res.status = ST_BAD;
        hit        = 1'b0;
        case (op)
            OP_INSERT:
            begin
                if (pos == 0)
                    res.status = ST_BAD;
                else if (shadow_count >= DEPTH)
                    res.status = ST_FULL;
                else if (shadow_count != 0 && int'(pos) > shadow_count + 1)
                    res.status = ST_BAD;
                else
                begin
                    // An empty list takes the value as its first entry whatever the nonzero position.
                    slot = (shadow_count == 0) ? 1 : int'(pos);
                    for (i = shadow_count; i >= slot; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[slot-1] = val;
                    shadow_count++;
                    res.status = ST_DONE;
                end
            end
            OP_APPEND:
            begin
                if (shadow_count >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    shadow_entries[shadow_count] = val;
                    shadow_count++;
                    res.status = ST_DONE;
                end
            end
            OP_DEL_POS:
            begin
                if (pos == 0 || shadow_count == 0 || int'(pos) > shadow_count)
                    res.status = ST_BAD;
                else
                begin
                    for (i = int'(pos); i < shadow_count; i++)
                        shadow_entries[i-1] = shadow_entries[i];
                    shadow_count--;
                    res.status = ST_DONE;
                end
            end
            OP_DEL_LAST:
            begin
                if (shadow_count == 0)
                    res.status = ST_BAD;
                else
                begin
                    shadow_count--;
                    res.status = ST_DONE;
                end
            end
            OP_SEARCH:
            begin
                res.status = ST_MISS;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (!hit && shadow_entries[i] == val)
                    begin
                        hit        = 1'b1;
                        res.fpos   = FPOS_W'(i + 1);
                        res.status = ST_DONE;
                    end
                end
            end
            default:
                res.status = ST_BAD;
        endcase
        res.ecnt = ECNT_W'(shadow_count);
    endtask

    always @(posedge clk)
    begin
        resp_t want;
        resp_t predicted;
        if (rst_n)
        begin
            // Results are compared first, so that a result can never be matched
            // with an operation that is accepted on the same edge.
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (waiting_cnt == 0)
                    report_mismatch("result with no operation waiting", 32'(m_tdata), 32'd0);
                else
                begin
                    want = awaited_results.pop_front();
                    waiting_cnt--;
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[FPOS_W-1:0] !== want.fpos)
                        report_mismatch("found_position", 32'(m_tdata[FPOS_W-1:0]),
                                        32'(want.fpos));
                    if (m_tdata[FPOS_W +: ECNT_W] !== want.ecnt)
                        report_mismatch("entry_count", 32'(m_tdata[FPOS_W +: ECNT_W]),
                                        32'(want.ecnt));
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_list_op(s_tuser, s_tdata[VAL_W-1:0], s_tdata[VAL_W +: POS_W], predicted);
                awaited_results.push_back(predicted);
                waiting_cnt++;
            end
        end
    end

endmodule

// File: tb/positional_ordered_list_top_tb.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_top_tb - testbench for the positional ordered list
// The testbench runs a short directed sequence over every operation and edge
// position. It then runs about a thousand random operations in grow, shrink
// and mixed phases. Both channels stall at random, and the result side holds
// off once for a long stretch. The checker module predicts and compares every
// result, and this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_ordered_list_top_tb;
    import pol_pkg::*;

    // Number of random operations after the directed part.
    localparam int RANDOM_ITEMS = 1000;
    // Watchdog limit, with a wide margin over the length of the whole run.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 80;
    // Long hold-off on the result side, so that the block backs up into its input.
    localparam int HOLD_CYCLES  = 200;

    typedef enum int {PHASE_GROW, PHASE_MIXED, PHASE_SHRINK} phase_kind_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: value [31:0], position [39:32]
    logic [IN_DATA_W-1:0]  s_tdata;
    // s_tuser: op [2:0]
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata: found_position [6:0], entry_count [13:7], zero padding above
    logic [OUT_DATA_W-1:0] m_tdata;
    // m_tuser: status [1:0]
    logic [ST_W-1:0]       m_tuser;

    int fail_count;
    int pending;
    int list_len;

    // Stimulus shaping shared between the sender and the receiver processes.
    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;
    int hold_ticket  = 0;
    int items_sent   = 0;
    int cycle_cnt    = 0;

    positional_ordered_list_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    positional_ordered_list_checker list_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .list_len   (list_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // This watchdog ends the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still waiting", cycle_cnt, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Most values come from a small pool, so that searches hit and lists
    // hold duplicates. The rest are full-width random values, so that every
    // bit of the field toggles.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom();
            default: return 32'($urandom_range(0, 11)) - 32'd4;
        endcase
    endfunction

    // Sends one transaction on the slave channel. The task is entered and
    // left at a falling edge. tvalid stays high into the next transaction
    // when no gap is drawn.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                           input logic [POS_W-1:0] position);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {position, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Lowers tvalid and waits until every result already predicted has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Receiver: before each result it draws a number of stall cycles with
    // tready low. When the sender asks for a hold-off, one of these stalls
    // is stretched to HOLD_CYCLES.
    initial
    begin : result_sink
        int wait_n;
        int hold_served;
        hold_served = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_n = rx_quiet ? 0 : $urandom_range(0, 8);
            if (hold_ticket != hold_served)
            begin
                hold_served = hold_ticket;
                wait_n      = HOLD_CYCLES;
            end
            if (wait_n > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : op_source
        int          k;
        int          r;
        int          phase_idx;
        int          phase_len;
        int          random_start;
        int          t [5];
        phase_kind_t kind;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. The first operations run on the empty list.
        send_op(OP_INSERT,   32'd7,          8'd0);    // Position zero on an empty list.
        send_op(OP_DEL_POS,  32'd0,          8'd1);    // Delete from the empty list.
        send_op(OP_DEL_LAST, 32'd0,          8'd0);
        send_op(OP_SEARCH,   32'd7,          8'd0);    // Search on the empty list.
        send_op(OP_INSERT,   32'h8000_0000,  8'd255);  // The empty list takes any position.
        send_op(OP_INSERT,   32'd1,          8'd3);    // Position beyond the end.
        send_op(OP_INSERT,   32'h7FFF_FFFF,  8'd2);    // Insert just behind the tail.
        send_op(OP_APPEND,   32'd0,          8'd0);
        send_op(OP_APPEND,   32'hFFFF_FFFF,  8'd255);
        send_op(OP_INSERT,   32'd5,          8'd1);    // New head.
        send_op(OP_INSERT,   32'd5,          8'd3);    // Duplicate in the middle.
        send_op(OP_SEARCH,   32'd5,          8'd0);    // The first match is the one reported.
        send_op(OP_SEARCH,   32'h7FFF_FFFF,  8'd0);
        send_op(OP_SEARCH,   32'hFFFF_FFFF,  8'd0);    // Match on the tail.
        send_op(OP_SEARCH,   32'd12345,      8'd0);    // No match.
        for (k = 5; k <= 7; k++)                       // Unused op codes.
            send_op(OP_W'(k), $urandom(), POS_W'($urandom_range(0, 255)));
        send_op(OP_INSERT,   32'd1,          8'd0);    // Position zero on a non-empty list.
        send_op(OP_DEL_POS,  32'd0,          8'd0);
        send_op(OP_DEL_POS,  32'd0,          8'd255);  // Delete beyond the end.
        send_op(OP_DEL_POS,  32'd0,          POS_W'(list_len));  // Delete the tail.
        send_op(OP_DEL_POS,  32'd0,          8'd1);    // Delete the head.
        send_op(OP_DEL_POS,  32'd0,          8'd2);    // Delete from the middle.
        send_op(OP_DEL_LAST, 32'd0,          8'd0);
        wait_drained();

        // Random part, in phases. Grow phases favour inserts and appends,
        // and shrink phases favour deletes.
        random_start = items_sent;
        phase_idx    = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case (phase_idx % 4)
                0:       kind = PHASE_GROW;
                2:       kind = PHASE_SHRINK;
                default: kind = PHASE_MIXED;
            endcase
            tx_quiet  = (phase_idx % 5 == 4);
            rx_quiet  = (phase_idx % 3 == 2);
            phase_len = $urandom_range(60, 150);
            if (phase_idx == 1)
                hold_ticket++;

            // Cumulative thresholds: insert, append, delete at position,
            // delete last, search. The rest are unused op codes.
            case (kind)
                PHASE_GROW:   t = '{35, 65, 75, 80, 95};
                PHASE_SHRINK: t = '{10, 15, 50, 70, 95};
                default:      t = '{20, 40, 60, 70, 95};
            endcase

            for (k = 0; k < phase_len; k++)
            begin
                r        = $urandom_range(0, 99);
                value    = pick_value();
                position = '0;
                if (r < t[0])
                    op = OP_INSERT;
                else if (r < t[1])
                    op = OP_APPEND;
                else if (r < t[2])
                    op = OP_DEL_POS;
                else if (r < t[3])
                    op = OP_DEL_LAST;
                else if (r < t[4])
                    op = OP_SEARCH;
                else
                begin
                    op       = OP_W'($urandom_range(5, 7));
                    value    = $urandom();
                    position = POS_W'($urandom_range(0, 255));
                end

                // Positions are mostly valid for the current length of the
                // list. The rest are zero, just past the end, or anywhere.
                if (op == OP_INSERT || op == OP_DEL_POS)
                begin
                    if ($urandom_range(0, 99) < 85)
                    begin
                        if (op == OP_INSERT)
                            position = POS_W'($urandom_range(1, list_len + 1));
                        else
                            position = (list_len > 0) ? POS_W'($urandom_range(1, list_len))
                                                      : 8'd1;
                    end
                    else
                    begin
                        case ($urandom_range(0, 3))
                            0:       position = 8'd0;
                            1:       position = (op == OP_INSERT) ? POS_W'(list_len + 2)
                                                                  : POS_W'(list_len + 1);
                            default: position = POS_W'($urandom_range(0, 255));
                        endcase
                    end
                end
                else if (op == OP_APPEND || op == OP_DEL_LAST || op == OP_SEARCH)
                    position = POS_W'($urandom_range(0, 255));

                send_op(op, value, position);
            end

            // The sender pauses between phases until every result has come back.
            wait_drained();
            phase_idx++;
        end

        tx_quiet = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
